/* rtl/mbr_pkg.sv */
// ----------------------------------------------------------------------------
// mbr_pkg
// Shared types and codes for the msb-first bit reader.
// ----------------------------------------------------------------------------
package mbr_pkg;

  // request op codes as they arrive on the input channel
  localparam logic [2:0] OP_LOAD    = 3'd0;
  localparam logic [2:0] OP_RESTART = 3'd1;
  localparam logic [2:0] OP_SHOW    = 3'd2;
  localparam logic [2:0] OP_GET     = 3'd3;
  localparam logic [2:0] OP_ALIGN   = 3'd4;

  // classified command kinds handed to the back end
  localparam logic [2:0] CMD_NOP     = 3'd0;
  localparam logic [2:0] CMD_LOAD    = 3'd1;
  localparam logic [2:0] CMD_RESTART = 3'd2;
  localparam logic [2:0] CMD_SHOW    = 3'd3;
  localparam logic [2:0] CMD_GET     = 3'd4;
  localparam logic [2:0] CMD_ALIGN   = 3'd5;

  localparam int WIN_BITS = 32;
  localparam int FILL_W   = 7;   // signed, -32..32
  localparam int Q_DEPTH  = 2;
  localparam int QIDX_W   = $clog2(Q_DEPTH);
  localparam int QCNT_W   = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic [5:0] cnt;    // already limited to 0..32
  } cmd_t;

  typedef struct packed {
    logic                     idle;
    logic                     pend;
    logic signed [FILL_W-1:0] fill;
  } back_status_t;

endpackage

/* rtl/mbr_in_if.sv */
// ----------------------------------------------------------------------------
// mbr_in_if
// Request channel of the bit reader: op, byte and bit count.
// ----------------------------------------------------------------------------
interface mbr_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] data_byte;
  logic [5:0] bit_count;

  modport source (output valid, output op, output data_byte, output bit_count,
                  input ready);
  modport sink   (input valid, input op, input data_byte, input bit_count,
                  output ready);
endinterface

/* rtl/mbr_out_if.sv */
// ----------------------------------------------------------------------------
// mbr_out_if
// Result channel of the bit reader: field value and counters.
// ----------------------------------------------------------------------------
interface mbr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] field_value;
  logic [31:0] bits_consumed;
  logic [15:0] overrun_count;

  modport source (output valid, output field_value, output bits_consumed,
                  output overrun_count, input ready);
  modport sink   (input valid, input field_value, input bits_consumed,
                  input overrun_count, output ready);
endinterface

/* rtl/mbr_front.sv */
// ----------------------------------------------------------------------------
// mbr_front
// Accepts requests and classifies them into back-end commands.
// ----------------------------------------------------------------------------
module mbr_front
  import mbr_pkg::*;
(
  mbr_in_if.sink in_ch,
  output logic   push_valid,
  input  logic   push_ready,
  output cmd_t   push_cmd
);

  always_comb begin
    case (in_ch.op)
      OP_LOAD:    push_cmd.kind = CMD_LOAD;
      OP_RESTART: push_cmd.kind = CMD_RESTART;
      OP_SHOW:    push_cmd.kind = CMD_SHOW;
      OP_GET:     push_cmd.kind = CMD_GET;
      OP_ALIGN:   push_cmd.kind = CMD_ALIGN;
      default:    push_cmd.kind = CMD_NOP;
    endcase
    push_cmd.data = in_ch.data_byte;
    // counts above a full window act as a full window
    push_cmd.cnt  = (in_ch.bit_count > 6'd32) ? 6'd32 : in_ch.bit_count;
  end

  assign push_valid  = in_ch.valid;
  assign in_ch.ready = push_ready;

endmodule

/* rtl/mbr_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// mbr_cmd_fifo
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module mbr_cmd_fifo
  import mbr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t              slot_r [Q_DEPTH];
  logic [QIDX_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push, do_pop;

  assign push_ready = (count_r != QCNT_W'(Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QIDX_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QIDX_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

/* rtl/mbr_back.sv */
// ----------------------------------------------------------------------------
// mbr_back
// Executes commands: byte store, bit window, refill sequencer, result register.
// ----------------------------------------------------------------------------
module mbr_back
  import mbr_pkg::*;
#(
  parameter int BUF_BYTES = 4096
)
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cmd_valid,
  output logic         cmd_ready,
  input  cmd_t         cmd,
  mbr_out_if.source    out_ch,
  output back_status_t status
);

  localparam int ADDR_W = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
  localparam int PTR_W  = $clog2(BUF_BYTES + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_FILL = 1'b1;

  logic [7:0]        store_mem [BUF_BYTES];
  logic [7:0]        rd_data_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;

  logic                     state_r, state_nxt;
  logic [PTR_W-1:0]         loaded_r, loaded_nxt;
  logic [PTR_W-1:0]         rp_r, rp_nxt;
  logic [WIN_BITS-1:0]      win_r, win_nxt;
  logic signed [FILL_W-1:0] fill_r, fill_nxt;
  logic [31:0]              cons_r, cons_nxt;
  logic [15:0]              ovr_r, ovr_nxt;
  logic [31:0]              val_r, val_nxt;
  logic                     pend_r, pend_nxt;
  logic [5:0]               place_r, place_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [31:0]              out_val_r, out_val_nxt;
  logic [31:0]              out_cons_r, out_cons_nxt;
  logic [15:0]              out_ovr_r, out_ovr_nxt;

  logic                     out_free, finish;
  logic [63:0]              byte_wide;
  logic [31:0]              peek;
  logic [2:0]               drop;
  logic signed [FILL_W-1:0] place_s;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_addr] <= cmd.data;
    end
    rd_data_r <= store_mem[mem_addr];
  end

  assign out_free  = !out_valid_r || out_ch.ready;
  assign byte_wide = {56'd0, rd_data_r} << place_r;
  assign peek      = (cmd.cnt == 6'd0) ? 32'd0 : (win_r >> (6'd32 - cmd.cnt));
  assign drop      = fill_r[2:0];
  assign place_s   = 7'sd24 - fill_r;

  always_comb begin
    state_nxt  = state_r;
    loaded_nxt = loaded_r;
    rp_nxt     = rp_r;
    win_nxt    = win_r;
    fill_nxt   = fill_r;
    cons_nxt   = cons_r;
    ovr_nxt    = ovr_r;
    val_nxt    = val_r;
    pend_nxt   = pend_r;
    place_nxt  = place_r;
    mem_we     = 1'b0;
    mem_addr   = rp_r[ADDR_W-1:0];
    cmd_ready  = 1'b0;
    finish     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_ready = 1'b1;
          val_nxt   = 32'd0;
          case (cmd.kind)
            CMD_LOAD: begin
              if (loaded_r < PTR_W'(BUF_BYTES)) begin
                mem_we     = 1'b1;
                mem_addr   = loaded_r[ADDR_W-1:0];
                loaded_nxt = loaded_r + 1'b1;
              end
              finish = 1'b1;
            end
            CMD_RESTART: begin
              rp_nxt    = '0;
              win_nxt   = '0;
              fill_nxt  = '0;
              cons_nxt  = '0;
              ovr_nxt   = '0;
              state_nxt = ST_FILL;
            end
            CMD_SHOW: begin
              val_nxt = peek;
              finish  = 1'b1;
            end
            CMD_GET: begin
              val_nxt   = peek;
              cons_nxt  = cons_r + {26'd0, cmd.cnt};
              win_nxt   = (cmd.cnt == 6'd32) ? 32'd0 : (win_r << cmd.cnt[4:0]);
              fill_nxt  = fill_r - signed'({1'b0, cmd.cnt});
              state_nxt = ST_FILL;
            end
            CMD_ALIGN: begin
              if (fill_r != 7'sd32) begin
                cons_nxt  = cons_r + {29'd0, drop};
                win_nxt   = win_r << drop;
                fill_nxt  = fill_r - signed'({4'd0, drop});
                state_nxt = ST_FILL;
              end else begin
                finish = 1'b1;
              end
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end
      ST_FILL: begin
        // merge the byte fetched last cycle
        if (pend_r) begin
          win_nxt = win_r | byte_wide[31:0];
        end
        pend_nxt = 1'b0;
        if (fill_r <= 7'sd24) begin
          if (rp_r < loaded_r) begin
            rp_nxt    = rp_r + 1'b1;
            pend_nxt  = 1'b1;
            place_nxt = place_s[5:0];
          end else if (ovr_r != 16'hFFFF) begin
            ovr_nxt = ovr_r + 1'b1;
          end
          fill_nxt = fill_r + 7'sd8;
        end else begin
          state_nxt = ST_IDLE;
          finish    = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_val_nxt   = out_val_r;
    out_cons_nxt  = out_cons_r;
    out_ovr_nxt   = out_ovr_r;
    if (finish) begin
      out_valid_nxt = 1'b1;
      out_val_nxt   = val_nxt;
      out_cons_nxt  = cons_nxt;
      out_ovr_nxt   = ovr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      loaded_r    <= '0;
      rp_r        <= '0;
      win_r       <= '0;
      fill_r      <= '0;
      cons_r      <= '0;
      ovr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      loaded_r    <= loaded_nxt;
      rp_r        <= rp_nxt;
      win_r       <= win_nxt;
      fill_r      <= fill_nxt;
      cons_r      <= cons_nxt;
      ovr_r       <= ovr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    place_r    <= place_nxt;
    out_val_r  <= out_val_nxt;
    out_cons_r <= out_cons_nxt;
    out_ovr_r  <= out_ovr_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.field_value   = out_val_r;
  assign out_ch.bits_consumed = out_cons_r;
  assign out_ch.overrun_count = out_ovr_r;

  assign status.idle = (state_r == ST_IDLE);
  assign status.pend = pend_r;
  assign status.fill = fill_r;

endmodule

/* rtl/msb_first_bit_reader.sv */
// ----------------------------------------------------------------------------
// msb_first_bit_reader: load, show, unused codes and align on a full window give
// a result once the back end takes them; restart, get and other aligns first
// refill the window, one store read per cycle and no command taken meanwhile:
// 4 bytes for restart, 0..4 for get and align, up to 8 while empty after reset
// throughput: one request per cycle for the short kinds while results are taken
// reset (rst_n low, synchronous) clears counters, window and queue; store is kept
// ----------------------------------------------------------------------------
module msb_first_bit_reader
  import mbr_pkg::*;
#(
  parameter int BUF_BYTES = 4096
)
(
  input  logic      clk,
  input  logic      rst_n,
  mbr_in_if.sink    in_ch,
  mbr_out_if.source out_ch
);

  // front to queue
  logic         push_valid, push_ready;
  cmd_t         push_cmd;
  // queue to back
  logic         q_valid, q_ready;
  cmd_t         q_cmd;
  back_status_t back_st;

  // front end: takes each request and classifies it into a command
  mbr_front u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // short queue so requests keep flowing while the back end refills
  mbr_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  // back end: byte store, window, refill sequencer and result register
  mbr_back #(
    .BUF_BYTES (BUF_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .out_ch    (out_ch),
    .status    (back_st)
  );

`ifndef NO_ASSERTIONS
  // between requests the window holds zero bits (only after reset) or 25..32
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    back_st.idle |-> (back_st.fill == 7'sd0 ||
                      (back_st.fill >= 7'sd25 && back_st.fill <= 7'sd32)))
    else $error("window fill out of range while idle");

  // no result appears without a queued request
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (!q_valid && back_st.idle && !out_ch.valid) |=> !out_ch.valid)
    else $error("result without a request");

  // an idle back end with a free result slot takes the next queued request
  a_pop_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (back_st.idle && q_valid && (!out_ch.valid || out_ch.ready)) |-> q_ready)
    else $error("back end stalled while free");

  // a pending store read only exists during refill
  a_pend_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    back_st.pend |-> (!back_st.idle && !out_ch.valid || !back_st.idle))
    else $error("pending store read outside refill");
`endif

endmodule

/* bench/mbr_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mbr_checker
// Watches both channels of the bit reader. Every accepted request is run
// through a local model of the window, the store and the counters. Every
// accepted result is compared against the oldest predicted one.
// ----------------------------------------------------------------------------
module mbr_checker
  import mbr_pkg::*;
#(
  parameter int BUF_BYTES = 4096
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic [7:0]  in_data_byte,
  input  logic [5:0]  in_bit_count,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_field_value,
  input  logic [31:0] out_bits_consumed,
  input  logic [15:0] out_overrun_count,
  output int          fail_count,
  output int          pending
);

  localparam int MAX_PRINTS = 100;

  typedef struct packed {
    logic [31:0] value;
    logic [31:0] consumed;
    logic [15:0] overruns;
  } reader_result_t;

  reader_result_t expected_q[$];

  // local copy of the reader state
  logic [7:0]  store_mem [BUF_BYTES];
  int          loaded;
  int          rptr;
  logic [31:0] window;
  int          fill;
  logic [31:0] consumed;
  logic [15:0] overruns;
  int          mismatches = 0;

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTS)
      $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h, want %h", name, got, want));
  endtask

  // top up the window byte by byte while 24 or fewer bits are valid
  task automatic refill_window();
    logic [63:0] byte_bits;
    int          place;
    while (fill <= 24) begin
      byte_bits = '0;
      place     = 24 - fill;
      if (rptr < loaded) begin
        byte_bits = 64'(store_mem[rptr]);
        rptr++;
      end else if (overruns != 16'hFFFF) begin
        overruns++;
      end
      window |= 32'(byte_bits << place);
      fill   += 8;
    end
  endtask

  task automatic consume_bits(input int n);
    consumed += 32'(n);
    window    = (n >= 32) ? 32'd0 : window << n;
    fill     -= n;
    refill_window();
  endtask

  function automatic logic [31:0] peek_bits(input int n);
    return (n == 0) ? 32'd0 : window >> (32 - n);
  endfunction

  task automatic step_reader(input logic [2:0] op, input logic [7:0] data,
                             input logic [5:0] count, output reader_result_t res);
    int n;
    n         = (count > 6'd32) ? 32 : int'(count);
    res.value = '0;
    case (op)
      OP_LOAD: begin
        if (loaded < BUF_BYTES) begin
          store_mem[loaded] = data;
          loaded++;
        end
      end
      OP_RESTART: begin
        rptr     = 0;
        window   = '0;
        fill     = 0;
        consumed = '0;
        overruns = '0;
        consume_bits(0);
      end
      OP_SHOW: res.value = peek_bits(n);
      OP_GET: begin
        res.value = peek_bits(n);
        consume_bits(n);
      end
      OP_ALIGN: begin
        if (fill != 32)
          consume_bits(fill & 7);
      end
      default: ;
    endcase
    res.consumed = consumed;
    res.overruns = overruns;
  endtask

  always @(posedge clk) begin
    reader_result_t want;
    reader_result_t got;
    if (!rst_n) begin
      // the store survives reset
      loaded   = 0;
      rptr     = 0;
      window   = '0;
      fill     = 0;
      consumed = '0;
      overruns = '0;
      expected_q.delete();
    end else begin
      // results first, so a stray result never matches a request of this edge
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with no request waiting");
        end else begin
          want = expected_q.pop_front();
          check_field("field_value", out_field_value, want.value);
          check_field("bits_consumed", out_bits_consumed, want.consumed);
          check_field("overrun_count", {16'd0, out_overrun_count}, {16'd0, want.overruns});
        end
      end
      if (in_valid && in_ready) begin
        step_reader(in_op, in_data_byte, in_bit_count, got);
        expected_q.push_back(got);
      end
    end
    pending    <= expected_q.size();
    fail_count <= mismatches;
  end

endmodule

/* bench/tb_msb_first_bit_reader.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_msb_first_bit_reader
// Regression for the msb-first bit reader. A short directed sequence hits the
// edges (empty store, counts 0, 32 and above, alignment, reads past the end),
// then random requests run under three pacing phases with long receiver
// hold-offs and a full drain pause. A side checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_msb_first_bit_reader
  import mbr_pkg::*;
();

  // small store so that the full-store case is reached within the run
  localparam int BUF_BYTES    = 128;
  localparam int PHASE_REQS   = 475;
  localparam int STALL_CYCLES = 80;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 400000;

  logic clk;
  logic rst_n;

  // pacing: phase 0 sender 34 / receiver 57, phase 1 swapped, phase 2 none
  int pace_phase;
  int send_idle_pct [3] = '{34, 57, 0};
  int recv_idle_pct [3] = '{57, 34, 0};

  // bumped by the stimulus, served by the receiver process
  int stall_requests;

  int cycle_count;
  int fail_count;
  int pending;

  mbr_in_if  req_if ();
  mbr_out_if res_if ();

  msb_first_bit_reader #(
    .BUF_BYTES (BUF_BYTES)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_if),
    .out_ch (res_if)
  );

  mbr_checker #(
    .BUF_BYTES (BUF_BYTES)
  ) i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (req_if.valid),
    .in_ready          (req_if.ready),
    .in_op             (req_if.op),
    .in_data_byte      (req_if.data_byte),
    .in_bit_count      (req_if.bit_count),
    .out_valid         (res_if.valid),
    .out_ready         (res_if.ready),
    .out_field_value   (res_if.field_value),
    .out_bits_consumed (res_if.bits_consumed),
    .out_overrun_count (res_if.overrun_count),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  // 8 ns clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // offer one request, with random idle cycles ahead of it, and hold it
  // until the reader takes it
  task automatic send_req(input logic [2:0] op, input logic [7:0] data,
                          input logic [5:0] count);
    while ($urandom_range(99) < send_idle_pct[pace_phase]) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.op        <= op;
    req_if.data_byte <= data;
    req_if.bit_count <= count;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  // random request: gets dominate, loads keep the store growing until full,
  // counts lean toward the edges, unused codes show up now and then
  task automatic send_random_req();
    int         pick;
    logic [2:0] op;
    logic [5:0] count;
    pick = $urandom_range(99);
    if (pick < 25)      op = OP_LOAD;
    else if (pick < 30) op = OP_RESTART;
    else if (pick < 45) op = OP_SHOW;
    else if (pick < 85) op = OP_GET;
    else if (pick < 95) op = OP_ALIGN;
    else                op = OP_ALIGN + 3'($urandom_range(3, 1));
    pick = $urandom_range(99);
    if (pick < 10)      count = 6'd0;
    else if (pick < 20) count = 6'd32;
    else if (pick < 28) count = 6'($urandom_range(63, 33));
    else                count = 6'($urandom_range(31, 1));
    send_req(op, 8'($urandom_range(255)), count);
  endtask

  // stop offering and wait for every predicted result to come back;
  // the checker is first let see the last accepted request
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // receiver: random back-pressure, plus long hold-offs on request
  initial begin
    int hold_left;
    int served;
    hold_left    = 0;
    served       = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (served < stall_requests) begin
        served++;
        hold_left = STALL_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_idle_pct[pace_phase]);
      end
    end
  end

  // run guard
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("msb_first_bit_reader regression: fail");
    $finish;
  end

  // stimulus and verdict
  initial begin
    req_if.valid     = 1'b0;
    req_if.op        = OP_LOAD;
    req_if.data_byte = '0;
    req_if.bit_count = '0;
    rst_n            = 1'b0;
    pace_phase       = 0;
    stall_requests   = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reads before any restart and with an empty store
    send_req(OP_SHOW, 8'h00, 6'd5);
    send_req(OP_GET,  8'h00, 6'd32);
    // bytes with all-ones, all-zeros and alternating patterns
    send_req(OP_LOAD, 8'hFF, 6'd0);
    send_req(OP_LOAD, 8'h00, 6'd0);
    send_req(OP_LOAD, 8'hA5, 6'd0);
    send_req(OP_LOAD, 8'h5A, 6'd0);
    send_req(OP_LOAD, 8'h80, 6'd0);
    send_req(OP_LOAD, 8'h01, 6'd0);
    send_req(OP_LOAD, 8'hFF, 6'd0);
    send_req(OP_LOAD, 8'h7E, 6'd0);
    send_req(OP_RESTART, 8'h00, 6'd0);
    // zero count, full window, count above 32
    send_req(OP_SHOW, 8'h00, 6'd0);
    send_req(OP_SHOW, 8'h00, 6'd32);
    send_req(OP_SHOW, 8'h00, 6'd63);
    // zero-bit get, then knock the window off byte alignment and realign
    send_req(OP_GET,   8'h00, 6'd0);
    send_req(OP_GET,   8'h00, 6'd1);
    send_req(OP_GET,   8'h00, 6'd7);
    send_req(OP_ALIGN, 8'h00, 6'd0);
    // run past the loaded bytes, then append while reading
    send_req(OP_GET,  8'h00, 6'd32);
    send_req(OP_LOAD, 8'hC3, 6'd0);
    send_req(OP_GET,  8'h00, 6'd17);
    // unused codes
    send_req(OP_ALIGN + 3'd1, 8'h00, 6'd0);
    send_req(OP_ALIGN + 3'd3, 8'hFF, 6'd63);
    send_req(OP_GET,     8'h00, 6'd32);
    send_req(OP_RESTART, 8'h00, 6'd0);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      pace_phase = phase;
      for (int idx = 0; idx < PHASE_REQS; idx++) begin
        // sender pause until every result is back
        if (phase == 0 && idx == PHASE_REQS / 2)
          wait_drained();
        // long receiver hold-off while the sender keeps pushing
        if (phase != 0 && idx == 100)
          stall_requests++;
        send_random_req();
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("msb_first_bit_reader regression: pass");
    else
      $display("msb_first_bit_reader regression: fail");
    $finish;
  end

endmodule
